/* sv/frame_allocator_oldest_victim_macros.svh */
// Assertion macros shared by the frame allocator RTL.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef FRAME_ALLOCATOR_OLDEST_VICTIM_MACROS_SVH
`define FRAME_ALLOCATOR_OLDEST_VICTIM_MACROS_SVH

// Property checked on every rising edge outside reset.
`define FAO_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define FAO_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* sv/fao_pkg.sv */
// Package for the frame allocator: transaction types, codes and defaults.
// Used by fao_ctrl and frame_allocator_oldest_victim.
`timescale 1ns / 1ps

package fao_pkg;

  localparam int FRAMES_DEF = 64;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_VICTIM = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NONE  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] owner_pid;
    logic [5:0]  frame_index;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  frame_out;
    logic [15:0] pid_out;
    logic [31:0] time_now;
  } out_item_t;

endpackage

/* sv/frame_allocator_oldest_victim.sv */
// Top level of the frame allocator: sequencer plus output register.
// Depends on fao_pkg and fao_ctrl.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | fao_pkg::in_item_t
//   out     | output    | out_valid_o/out_stall_i | fao_pkg::out_item_t
//
// Free and owner query go straight to the named entry; a query waits for the registered table read.
// Allocate scans from frame 0 and stops at the first free frame; a full table
// or victim select scans every entry, reading one table entry per cycle.
// After reset a clearing pass zeroes the table; no input
// transaction is taken until it ends.
// A stalled output holds its result; the next transaction is taken meanwhile.
`timescale 1ns / 1ps

module frame_allocator_oldest_victim #(
  parameter int FRAMES = fao_pkg::FRAMES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fao_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fao_pkg::out_item_t out_data_o
);
  import fao_pkg::*;

  logic      res_valid;
  logic      res_take;
  out_item_t res_data;
  logic      out_valid_q;
  out_item_t out_q;

  fao_ctrl #(.FRAMES(FRAMES)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_data_o  (res_data)
  );

  // Load when the register is empty or its transaction completes now.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (res_take) begin
        out_valid_q <= 1'b1;
        out_q       <= res_data;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/fao_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module fao_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/fao_ctrl.sv */
// Frame table sequencer: clearing pass, table scans, free and owner query.
// Depends on fao_pkg, fao_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "frame_allocator_oldest_victim_macros.svh"

module fao_ctrl #(
  parameter int FRAMES = fao_pkg::FRAMES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fao_pkg::in_item_t  in_data_i,
  output logic               res_valid_o,
  input  logic               res_take_i,
  output fao_pkg::out_item_t res_data_o
);
  import fao_pkg::*;

  localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int IW = (AW > 6) ? AW : 6;
  localparam logic [CW-1:0] LAST  = CW'(FRAMES);
  localparam logic [CW-1:0] LAST1 = CW'(FRAMES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_QWAIT,
    S_FINISH
  } state_e;

  state_e      state_q;
  mode_e       op_q;
  logic [15:0] pid_q;
  logic [CW-1:0] cnt_q;
  logic        chk_q;
  logic [AW-1:0] chk_addr_q;
  logic [31:0] best_q;
  logic [AW-1:0] best_idx_q;
  logic        found_q;
  logic [31:0] counter_q;
  out_item_t   res_q;

  logic          in_take;
  logic          idx_ok;
  logic [IW-1:0] idx_ext;
  logic [AW-1:0] idx_addr;
  logic [AW-1:0] scan_addr;
  logic [IW-1:0] chk_ext;
  logic [IW-1:0] best_ext;
  logic          alloc_hit;
  logic          victim_better;
  logic          scan_end;

  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          used_we;
  logic          used_wdata;
  logic          used_rdata;
  logic          meta_we;
  logic [47:0]   meta_wdata;
  logic [47:0]   meta_rdata;
  logic [31:0]   stamp_rdata;

  fao_ram #(.WIDTH(1), .DEPTH(FRAMES)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (waddr),
    .wdata_i (used_wdata),
    .raddr_i (raddr),
    .rdata_o (used_rdata)
  );

  // Owner pid in the upper 16 bits, allocation stamp in the lower 32.
  fao_ram #(.WIDTH(48), .DEPTH(FRAMES)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (waddr),
    .wdata_i (meta_wdata),
    .raddr_i (raddr),
    .rdata_o (meta_rdata)
  );

  assign stamp_rdata = meta_rdata[31:0];

  assign in_take    = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign idx_ext  = IW'(in_data_i.frame_index);
  assign idx_addr = idx_ext[AW-1:0];
  assign idx_ok   = ({26'd0, in_data_i.frame_index} < 32'(FRAMES));

  assign scan_addr = (cnt_q != LAST) ? cnt_q[AW-1:0] : '0;
  assign chk_ext   = IW'(chk_addr_q);
  assign best_ext  = IW'(best_idx_q);

  assign alloc_hit     = (state_q == S_SCAN) && (op_q == MODE_ALLOC) && chk_q && !used_rdata;
  assign victim_better = (state_q == S_SCAN) && (op_q == MODE_VICTIM) && chk_q &&
                         used_rdata && (stamp_rdata < best_q);
  assign scan_end      = !chk_q && (cnt_q == LAST);

  always_comb begin
    raddr      = idx_addr;
    waddr      = idx_addr;
    used_we    = 1'b0;
    used_wdata = 1'b0;
    meta_we    = 1'b0;
    meta_wdata = {pid_q, counter_q};
    unique case (state_q)
      S_CLEAR: begin
        waddr      = cnt_q[AW-1:0];
        used_we    = 1'b1;
        meta_we    = 1'b1;
        meta_wdata = '0;
      end
      S_IDLE: begin
        // Free only drops the in-use mark; owner and stamp stay.
        if (in_take && (in_data_i.mode == MODE_FREE) && idx_ok) begin
          used_we = 1'b1;
        end
      end
      S_SCAN: begin
        raddr = scan_addr;
        waddr = chk_addr_q;
        if (alloc_hit) begin
          used_we    = 1'b1;
          used_wdata = 1'b1;
          meta_we    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      op_q       <= MODE_ALLOC;
      pid_q      <= '0;
      cnt_q      <= '0;
      chk_q      <= 1'b0;
      chk_addr_q <= '0;
      best_q     <= '1;
      best_idx_q <= '0;
      found_q    <= 1'b0;
      counter_q  <= '0;
      res_q      <= '0;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (cnt_q == LAST1) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            op_q            <= in_data_i.mode;
            pid_q           <= in_data_i.owner_pid;
            cnt_q           <= '0;
            chk_q           <= 1'b0;
            found_q         <= 1'b0;
            best_q          <= '1;
            res_q.frame_out <= '0;
            res_q.pid_out   <= '0;
            res_q.time_now  <= '0;
            case (in_data_i.mode) inside
              MODE_ALLOC, MODE_VICTIM: begin
                res_q.status <= ST_OK;
                state_q      <= S_SCAN;
              end
              MODE_FREE: begin
                res_q.status <= idx_ok ? ST_OK : ST_RANGE;
                state_q      <= S_FINISH;
              end
              default: begin
                res_q.status <= idx_ok ? ST_OK : ST_RANGE;
                state_q      <= idx_ok ? S_QWAIT : S_FINISH;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Issue the next read while the previous entry is checked.
          chk_q      <= (cnt_q != LAST);
          chk_addr_q <= scan_addr;
          if (cnt_q != LAST) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (victim_better) begin
            best_q     <= stamp_rdata;
            best_idx_q <= chk_addr_q;
            found_q    <= 1'b1;
          end
          if (alloc_hit) begin
            res_q.frame_out <= chk_ext[5:0];
            counter_q       <= counter_q + 32'd1;
            state_q         <= S_FINISH;
          end else if (scan_end) begin
            if (op_q == MODE_ALLOC) begin
              res_q.status <= ST_FULL;
            end else if (found_q) begin
              res_q.frame_out <= best_ext[5:0];
            end else begin
              res_q.status <= ST_NONE;
            end
            state_q <= S_FINISH;
          end
        end
        S_QWAIT: begin
          res_q.pid_out <= meta_rdata[47:32];
          state_q       <= S_FINISH;
        end
        S_FINISH: begin
          if (res_take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res_data_o          = res_q;
    res_data_o.time_now = counter_q;
  end
  assign res_valid_o = (state_q == S_FINISH);

  `FAO_ASSERT(a_alloc_advance, alloc_hit |=> counter_q == $past(counter_q) + 32'd1, "alloc must advance counter by one")
  `FAO_ASSERT(a_cnt_bound, cnt_q <= LAST, "scan counter beyond table size")
  `FAO_ASSERT_NEVER(a_victim_no_write, (state_q == S_SCAN) && (op_q == MODE_VICTIM) && (used_we || meta_we), "table written during victim scan")
  `FAO_ASSERT(a_found_best, found_q |-> best_q != '1, "victim candidate holds all-ones stamp")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for frame_allocator_oldest_victim: allocate, free, victim select
// and owner query against a behavioral table model, under random idling and back-pressure.
// Depends on fao_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_top;
  import fao_pkg::*;

  localparam int FRAMES = FRAMES_DEF;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int MAX_REPORTS = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_item_t  out_data_o;

  // Behavioral copy of the frame table.
  logic        slot_busy [FRAMES];
  logic [15:0] slot_pid [FRAMES];
  logic [31:0] slot_stamp [FRAMES];
  logic [31:0] alloc_clock;

  out_item_t   pending_results [$];
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_output = 1'b0;
  int          fail_count;
  int          mode_seen [4];
  int          status_seen [4];
  int          input_stall_cycles;

  frame_allocator_oldest_victim #(
    .FRAMES(FRAMES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Update the table model with one transaction and return the result it must produce.
  function automatic out_item_t apply_frame_op(input in_item_t op);
    out_item_t   res;
    logic [31:0] oldest;
    res = '0;
    res.status = ST_OK;
    case (op.mode)
      MODE_ALLOC: begin
        res.status = ST_FULL;
        for (int k = 0; k < FRAMES; k++) begin
          if (res.status == ST_FULL && !slot_busy[k]) begin
            slot_busy[k] = 1'b1;
            slot_pid[k] = op.owner_pid;
            slot_stamp[k] = alloc_clock;
            alloc_clock = alloc_clock + 32'd1;
            res.frame_out = 6'(k);
            res.status = ST_OK;
          end
        end
      end
      MODE_FREE: begin
        if (int'(op.frame_index) < FRAMES) slot_busy[op.frame_index] = 1'b0;
        else res.status = ST_RANGE;
      end
      MODE_VICTIM: begin
        // Strictly below all-ones, so a frame stamped all-ones is never picked.
        oldest = '1;
        res.status = ST_NONE;
        for (int k = 0; k < FRAMES; k++) begin
          if (slot_busy[k] && slot_stamp[k] < oldest) begin
            oldest = slot_stamp[k];
            res.frame_out = 6'(k);
            res.status = ST_OK;
          end
        end
      end
      default: begin
        if (int'(op.frame_index) < FRAMES) res.pid_out = slot_pid[op.frame_index];
        else res.status = ST_RANGE;
      end
    endcase
    res.time_now = alloc_clock;
    return res;
  endfunction

  // Offer one transaction, hold it until accepted, then record its expected result.
  task automatic send_item(input mode_e m, input logic [15:0] pid, input logic [5:0] idx);
    in_item_t op;
    op.mode = m;
    op.owner_pid = pid;
    op.frame_index = idx;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= op;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_frame_op(op));
    mode_seen[m]++;
  endtask

  // Random transaction; frees and queries mostly target frames in use.
  task automatic send_random_op(input int alloc_pct);
    int          busy_list [$];
    int          pick;
    logic [5:0]  idx;
    idx = 6'($urandom_range(63));
    if ($urandom_range(99) < alloc_pct) begin
      send_item(MODE_ALLOC, 16'($urandom), idx);
    end else begin
      for (int k = 0; k < FRAMES; k++) if (slot_busy[k]) busy_list.push_back(k);
      if (busy_list.size() != 0 && $urandom_range(9) < 8)
        idx = 6'(busy_list[$urandom_range(busy_list.size() - 1)]);
      pick = $urandom_range(99);
      if (pick < 45) send_item(MODE_FREE, 16'($urandom), idx);
      else if (pick < 70) send_item(MODE_VICTIM, 16'($urandom), idx);
      else send_item(MODE_QUERY, 16'($urandom), idx);
    end
  endtask

  task automatic test_empty_table();
    send_item(MODE_VICTIM, 16'h0000, 6'd0);
    send_item(MODE_QUERY, 16'hFFFF, 6'd0);
    send_item(MODE_QUERY, 16'h0000, 6'd63);
    send_item(MODE_FREE, 16'h1234, 6'd17);
    send_item(MODE_FREE, 16'h0000, 6'd63);
  endtask

  task automatic test_lowest_free_oldest_victim();
    send_item(MODE_ALLOC, 16'hFFFF, 6'd63);
    send_item(MODE_ALLOC, 16'h0000, 6'd0);
    send_item(MODE_ALLOC, 16'hA5A5, 6'd21);
    send_item(MODE_VICTIM, 16'h0000, 6'd0);
    send_item(MODE_FREE, 16'h0000, 6'd0);
    send_item(MODE_VICTIM, 16'h0000, 6'd0);
    // Freed frame 0 is reused but now carries the newest stamp.
    send_item(MODE_ALLOC, 16'h5A5A, 6'd42);
    send_item(MODE_VICTIM, 16'h0000, 6'd0);
    send_item(MODE_QUERY, 16'h0000, 6'd0);
    send_item(MODE_FREE, 16'h0000, 6'd1);
    send_item(MODE_FREE, 16'h0000, 6'd2);
    send_item(MODE_VICTIM, 16'h0000, 6'd0);
    // A free frame still reports its last owner.
    send_item(MODE_QUERY, 16'h0000, 6'd1);
    send_item(MODE_QUERY, 16'h0000, 6'd2);
    send_item(MODE_FREE, 16'h0000, 6'd0);
    send_item(MODE_VICTIM, 16'hFFFF, 6'd63);
  endtask

  task automatic test_fill_and_drain();
    int order [$];
    repeat (FRAMES + 2) send_item(MODE_ALLOC, 16'($urandom), 6'($urandom));
    send_item(MODE_VICTIM, 16'($urandom), 6'($urandom));
    for (int k = 0; k < FRAMES; k++) order.push_back(k);
    order.shuffle();
    foreach (order[i]) begin
      send_item(MODE_FREE, 16'($urandom), 6'(order[i]));
      if (i % 2 == 0) send_item(MODE_VICTIM, 16'($urandom), 6'($urandom));
      else send_item(MODE_QUERY, 16'($urandom), 6'(order[i]));
    end
    send_item(MODE_VICTIM, 16'($urandom), 6'($urandom));
  endtask

  // Hold the output for a long stretch so the block backs up into its input.
  task automatic test_output_holdoff();
    fork
      begin
        hold_output <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
        hold_output <= 1'b0;
      end
    join_none
    repeat (30) send_random_op(50);
  endtask

  task automatic test_random_traffic(input int count);
    int alloc_pct;
    alloc_pct = 50;
    for (int i = 0; i < count; i++) begin
      // Shift the allocate bias in bursts so the table swings between full and empty.
      if (i % 25 == 0) alloc_pct = $urandom_range(10, 80);
      send_random_op(alloc_pct);
    end
  endtask

  // Output side: check accepted results, then choose the stall for the next cycle.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && in_valid_i && in_stall_o) input_stall_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result %p", $time, out_data_o);
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (out_data_o.status !== want.status) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: status expected %s got %0d", $time, want.status.name(),
                     out_data_o.status);
        end
        if (out_data_o.frame_out !== want.frame_out) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: frame_out expected %0d got %0d", $time, want.frame_out,
                     out_data_o.frame_out);
        end
        if (out_data_o.pid_out !== want.pid_out) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: pid_out expected 0x%h got 0x%h", $time, want.pid_out,
                     out_data_o.pid_out);
        end
        if (out_data_o.time_now !== want.time_now) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: time_now expected %0d got %0d", $time, want.time_now,
                     out_data_o.time_now);
        end
      end
    end
    out_stall_i <= hold_output || (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    fail_count = 0;
    input_stall_cycles = 0;
    foreach (mode_seen[i]) mode_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    for (int k = 0; k < FRAMES; k++) begin
      slot_busy[k] = 1'b0;
      slot_pid[k] = '0;
      slot_stamp[k] = '0;
    end
    alloc_clock = '0;
    send_idle_pct = 15;
    recv_idle_pct = 64;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_lowest_free_oldest_victim();
    test_fill_and_drain();
    test_random_traffic(250);

    send_idle_pct <= 64;
    recv_idle_pct <= 15;
    test_random_traffic(250);
    test_output_holdoff();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    test_fill_and_drain();
    test_random_traffic(200);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (FRAMES + 8) @(posedge clk_i);

    $display("Sent %0d alloc, %0d free, %0d victim, %0d query transactions",
             mode_seen[MODE_ALLOC], mode_seen[MODE_FREE], mode_seen[MODE_VICTIM],
             mode_seen[MODE_QUERY]);
    $display("Results: %0d ok, %0d table full, %0d no victim; input stalled %0d cycles",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NONE],
             input_stall_cycles);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Timeout watchdog, far beyond the slowest correct run.
  initial begin
    #12_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
